// File: src/tsme_pkg.sv
// ----------------------------------------------------------------------------
// tsme_pkg
// Shared types and codes of the schedule makespan evaluator.
// ----------------------------------------------------------------------------
package tsme_pkg;

    localparam logic [1:0] OP_RUN_TIME = 2'd0;
    localparam logic [1:0] OP_ROUTING  = 2'd1;
    localparam logic [1:0] OP_EDGE     = 2'd2;
    localparam logic [1:0] OP_TOUR     = 2'd3;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
    localparam logic [3:0]  CORE_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  task_index;
        logic [2:0]  core_index;
        logic [5:0]  other_index;
        logic [15:0] value;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [31:0] makespan;
        logic        saturated;
    } result_t;

endpackage

// File: src/tsme_if.sv
// ----------------------------------------------------------------------------
// tsme_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface tsme_item_if;
    logic            valid;
    logic            ready;
    tsme_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsme_result_if;
    logic              valid;
    logic              ready;
    tsme_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/tsme_ram.sv
// ----------------------------------------------------------------------------
// tsme_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/task_schedule_makespan_eval.sv
// ----------------------------------------------------------------------------
// task_schedule_makespan_eval
// Evaluates the makespan of a task-to-core schedule over a precedence graph.
// ----------------------------------------------------------------------------
// usage:
//   item channel carries table loads (run time, routing cost, edge) and tour
//   entries. an edge beat is a row read, then a row write. a tour beat with
//   last set starts the walk and no further beat is taken until its result
//   is out. the walk is bound by the single saturating adder and comparator
//   that every time update shares, and by one successor bit scanned per
//   cycle, held while a successor's ready time is updated; then the finish
//   times of the first core_count cores (at most MAX_CORES) give the result.
//   result channel gives one beat per evaluation from an output register;
//   a stalled receiver holds the block in its final state, loads wait.
//   reset clears the tour length, core count goes to 8, edge rows, task
//   mapping and ready times read as zero through valid flags, so there is
//   no clearing pass. run time and routing tables are undefined until
//   written. configuration: apb register 0 (core_count) at address 0.
// ----------------------------------------------------------------------------
module task_schedule_makespan_eval #(
    parameter int MAX_TASKS = 64,
    parameter int MAX_CORES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tsme_item_if.sink            item,
    tsme_result_if.source        result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [0:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int TW    = $clog2(MAX_TASKS);
    localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int LW    = $clog2(MAX_TASKS + 1);
    localparam int JW    = $clog2(MAX_CORES + 1);
    localparam int RT_D  = MAX_TASKS * MAX_CORES;
    localparam int RT_AW = (RT_D > 1) ? $clog2(RT_D) : 1;
    localparam int RC_D  = MAX_CORES * MAX_CORES;
    localparam int RC_AW = (RC_D > 1) ? $clog2(RC_D) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EDGE = 4'd1;
    localparam logic [3:0] S_TOUR = 4'd2;
    localparam logic [3:0] S_TASK = 4'd3;
    localparam logic [3:0] S_CORE = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_ADD  = 4'd6;
    localparam logic [3:0] S_SCAN = 4'd7;
    localparam logic [3:0] S_RT   = 4'd8;
    localparam logic [3:0] S_EST  = 4'd9;
    localparam logic [3:0] S_UPD  = 4'd10;
    localparam logic [3:0] S_MAX  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]            state_reg;
    logic [3:0]            core_count_reg;
    logic [LW-1:0]         tour_len_reg;
    logic [LW-1:0]         i_reg;
    logic [LW-1:0]         s_reg;
    logic [JW-1:0]         j_reg;
    logic [TW-1:0]         task_reg;
    logic [CW-1:0]         core_reg;
    logic [31:0]           ready_reg;
    logic [31:0]           start_reg;
    logic [31:0]           fin_reg;
    logic [31:0]           est_reg;
    logic [31:0]           best_reg;
    logic                  sat_reg;
    logic [MAX_TASKS-1:0]  row_reg;
    logic [TW-1:0]         edge_task_reg;
    logic [TW-1:0]         edge_other_reg;
    logic                  edge_bit_reg;
    logic [31:0]           cf_reg [MAX_CORES];
    logic [MAX_TASKS-1:0]  succ_valid_reg;
    logic [MAX_TASKS-1:0]  map_valid_reg;
    logic [MAX_TASKS-1:0]  rdy_valid_reg;
    logic                  out_valid_reg;
    tsme_pkg::result_t     out_data_reg;

    // input decode
    logic          in_fire;
    logic [31:0]   task32, core32, other32;
    logic          task_ok, core_ok, other_task_ok, other_core_ok;
    logic [TW-1:0] task_idx, other_tidx;
    logic [CW-1:0] core_idx, other_cidx;

    assign in_fire       = item.valid && item.ready;
    assign task32        = 32'(item.data.task_index);
    assign core32        = 32'(item.data.core_index);
    assign other32       = 32'(item.data.other_index);
    assign task_ok       = task32 < 32'(MAX_TASKS);
    assign core_ok       = core32 < 32'(MAX_CORES);
    assign other_task_ok = other32 < 32'(MAX_TASKS);
    assign other_core_ok = other32 < 32'(MAX_CORES);
    assign task_idx      = task32[TW-1:0];
    assign core_idx      = core32[CW-1:0];
    assign other_tidx    = other32[TW-1:0];
    assign other_cidx    = other32[CW-1:0];

    function automatic logic [RC_AW-1:0] rc_key(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] k;
        lo = (a < b) ? 32'(a) : 32'(b);
        hi = (a < b) ? 32'(b) : 32'(a);
        k  = lo * MAX_CORES + hi;
        return k[RC_AW-1:0];
    endfunction

    function automatic logic [RT_AW-1:0] rt_key(input logic [TW-1:0] t, input logic [CW-1:0] c);
        logic [31:0] k;
        k = 32'(t) * MAX_CORES + 32'(c);
        return k[RT_AW-1:0];
    endfunction

    // memories
    logic                 rt_we, rc_we, succ_we, map_we, tour_we, rdy_we;
    logic [RT_AW-1:0]     rt_waddr, rt_raddr;
    logic [RC_AW-1:0]     rc_waddr, rc_raddr;
    logic [TW-1:0]        succ_waddr, succ_raddr, map_waddr, map_raddr;
    logic [TW-1:0]        tour_waddr, tour_raddr, rdy_waddr, rdy_raddr;
    logic [MAX_TASKS-1:0] succ_wdata, succ_rdata;
    logic [15:0]          rt_rdata, rc_rdata;
    logic [CW-1:0]        map_rdata;
    logic [TW-1:0]        tour_rdata;
    logic [31:0]          rdy_rdata;

    logic [TW-1:0]        s_idx;
    logic [CW-1:0]        core_now;
    logic [CW-1:0]        their_now;
    logic [MAX_TASKS-1:0] edge_base;
    logic [LW-1:0]        tour_len_next;

    assign s_idx     = s_reg[TW-1:0];
    assign core_now  = map_valid_reg[task_reg] ? map_rdata : '0;
    assign their_now = map_valid_reg[s_idx] ? map_rdata : '0;

    always_comb
    begin
        edge_base = succ_valid_reg[edge_task_reg] ? succ_rdata : '0;
        edge_base[edge_other_reg] = edge_bit_reg;
    end

    assign rt_we      = in_fire && item.data.op == tsme_pkg::OP_RUN_TIME && task_ok && core_ok;
    assign rt_waddr   = rt_key(task_idx, core_idx);
    assign rt_raddr   = rt_key(task_reg, (state_reg == S_CORE) ? core_now : core_reg);
    assign rc_we      = in_fire && item.data.op == tsme_pkg::OP_ROUTING && core_ok && other_core_ok;
    assign rc_waddr   = rc_key(core_idx, other_cidx);
    assign rc_raddr   = rc_key(core_reg, their_now);
    assign succ_we    = state_reg == S_EDGE;
    assign succ_waddr = edge_task_reg;
    assign succ_wdata = edge_base;
    assign succ_raddr = (state_reg == S_TASK) ? tour_rdata : task_idx;
    assign map_we     = in_fire && item.data.op == tsme_pkg::OP_TOUR && task_ok && core_ok;
    assign map_waddr  = task_idx;
    assign map_raddr  = (state_reg == S_TASK) ? tour_rdata : s_idx;
    assign tour_we    = map_we && tour_len_reg < LW'(MAX_TASKS);
    assign tour_waddr = tour_len_reg[TW-1:0];
    assign tour_raddr = i_reg[TW-1:0];
    assign rdy_we     = state_reg == S_UPD && est_reg > ready_reg;
    assign rdy_waddr  = s_idx;
    assign rdy_raddr  = (state_reg == S_TASK) ? tour_rdata : s_idx;
    assign tour_len_next = tour_we ? tour_len_reg + LW'(1) : tour_len_reg;

    tsme_ram #(.WIDTH(16), .DEPTH(RT_D)) u_rt_ram (
        .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(item.data.value),
        .raddr(rt_raddr), .rdata(rt_rdata));
    tsme_ram #(.WIDTH(16), .DEPTH(RC_D)) u_rc_ram (
        .clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(item.data.value),
        .raddr(rc_raddr), .rdata(rc_rdata));
    tsme_ram #(.WIDTH(MAX_TASKS), .DEPTH(MAX_TASKS)) u_succ_ram (
        .clk(clk), .we(succ_we), .waddr(succ_waddr), .wdata(succ_wdata),
        .raddr(succ_raddr), .rdata(succ_rdata));
    tsme_ram #(.WIDTH(CW), .DEPTH(MAX_TASKS)) u_map_ram (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(core_idx),
        .raddr(map_raddr), .rdata(map_rdata));
    tsme_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_tour_ram (
        .clk(clk), .we(tour_we), .waddr(tour_waddr), .wdata(task_idx),
        .raddr(tour_raddr), .rdata(tour_rdata));
    tsme_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_rdy_ram (
        .clk(clk), .we(rdy_we), .waddr(rdy_waddr), .wdata(est_reg),
        .raddr(rdy_raddr), .rdata(rdy_rdata));

    // shared saturating adder and comparator
    logic [31:0] add_a, add_b, cmp_a, cmp_b, cf_sel;
    logic [32:0] add_sum;
    logic [31:0] add_res;
    logic        add_sat, cmp_gt;

    assign cf_sel = cf_reg[(state_reg == S_MAX) ? j_reg[CW-1:0] : core_reg];

    always_comb
    begin
        add_a = fin_reg;
        add_b = 32'(rc_rdata);
        cmp_a = est_reg;
        cmp_b = ready_reg;
        case (state_reg)
            S_ADD:
            begin
                add_a = start_reg;
                add_b = 32'(rt_rdata);
            end
            S_FIN:
            begin
                cmp_a = cf_sel;
                cmp_b = ready_reg;
            end
            S_MAX:
            begin
                cmp_a = cf_sel;
                cmp_b = best_reg;
            end
            default:
            begin
                add_a = fin_reg;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};
    assign add_sat = add_sum >= {1'b0, tsme_pkg::TIME_MAX};
    assign add_res = add_sat ? tsme_pkg::TIME_MAX : add_sum[31:0];
    assign cmp_gt  = cmp_a > cmp_b;

    logic cores_left;
    assign cores_left = 32'(j_reg) < 32'(MAX_CORES) && 32'(j_reg) < 32'(core_count_reg);

    // final state hands its result to the output register
    logic done_fire;
    assign done_fire = state_reg == S_DONE && (!out_valid_reg || result.ready);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            core_count_reg <= tsme_pkg::CORE_COUNT_RESET;
            tour_len_reg   <= '0;
            succ_valid_reg <= '0;
            map_valid_reg  <= '0;
            rdy_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
            sat_reg        <= 1'b0;
            i_reg          <= '0;
            s_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 1'b0)
            begin
                core_count_reg <= pwdata[3:0];
            end
            if (result.valid && result.ready && !done_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (item.data.op)
                            tsme_pkg::OP_EDGE:
                            begin
                                if (task_ok && other_task_ok)
                                begin
                                    edge_task_reg  <= task_idx;
                                    edge_other_reg <= other_tidx;
                                    edge_bit_reg   <= item.data.value[0];
                                    state_reg      <= S_EDGE;
                                end
                            end
                            tsme_pkg::OP_TOUR:
                            begin
                                if (map_we)
                                begin
                                    map_valid_reg[task_idx] <= 1'b1;
                                end
                                tour_len_reg <= tour_len_next;
                                if (item.data.last)
                                begin
                                    rdy_valid_reg <= '0;
                                    sat_reg       <= 1'b0;
                                    i_reg         <= '0;
                                    j_reg         <= '0;
                                    best_reg      <= '0;
                                    for (int c = 0; c < MAX_CORES; c++)
                                    begin
                                        cf_reg[c] <= '0;
                                    end
                                    state_reg <= (tour_len_next == '0) ? S_MAX : S_TOUR;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EDGE:
                begin
                    succ_valid_reg[edge_task_reg] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_TOUR:
                begin
                    state_reg <= S_TASK;
                end
                S_TASK:
                begin
                    task_reg  <= tour_rdata;
                    state_reg <= S_CORE;
                end
                S_CORE:
                begin
                    core_reg  <= core_now;
                    ready_reg <= rdy_valid_reg[task_reg] ? rdy_rdata : '0;
                    row_reg   <= succ_valid_reg[task_reg] ? succ_rdata : '0;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    start_reg <= cmp_gt ? cf_sel : ready_reg;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    fin_reg          <= add_res;
                    cf_reg[core_reg] <= add_res;
                    sat_reg          <= sat_reg | add_sat;
                    s_reg            <= '0;
                    state_reg        <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (s_reg == LW'(MAX_TASKS))
                    begin
                        i_reg     <= i_reg + LW'(1);
                        state_reg <= (i_reg + LW'(1) >= tour_len_reg) ? S_MAX : S_TOUR;
                    end
                    else if (row_reg[s_idx])
                    begin
                        state_reg <= S_RT;
                    end
                    else
                    begin
                        s_reg <= s_reg + LW'(1);
                    end
                end
                S_RT:
                begin
                    ready_reg <= rdy_valid_reg[s_idx] ? rdy_rdata : '0;
                    state_reg <= S_EST;
                end
                S_EST:
                begin
                    est_reg   <= add_res;
                    sat_reg   <= sat_reg | add_sat;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (cmp_gt)
                    begin
                        rdy_valid_reg[s_idx] <= 1'b1;
                    end
                    s_reg     <= s_reg + LW'(1);
                    state_reg <= S_SCAN;
                end
                S_MAX:
                begin
                    if (cores_left)
                    begin
                        if (cmp_gt)
                        begin
                            best_reg <= cf_sel;
                        end
                        j_reg <= j_reg + JW'(1);
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_data_reg.makespan  <= best_reg;
                        out_data_reg.saturated <= sat_reg;
                        tour_len_reg           <= '0;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item.ready   = state_reg == S_IDLE;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr == 1'b0) ? {28'd0, core_count_reg} : 32'd0;

`ifndef SYNTHESIS
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result beat raised outside final state");
    a_tour_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tour_len_reg <= LW'(MAX_TASKS))
        else $error("tour length beyond capacity");
    a_done_clears_tour: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || result.ready)) |=> tour_len_reg == '0)
        else $error("tour length not cleared after evaluation");
`endif

endmodule
